// File: rtl/ttmn_pkg.sv
// ----------------------------------------------------------------------------
// ttmn_pkg
// Shared types and constants for the tree token mutex node: node modes,
// message kinds, status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package ttmn_pkg;

  localparam int DEF_QUEUE_DEPTH  = 32;
  localparam int DEF_SITE_ID_BITS = 16;

  // configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int UPLINK_CFG_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_START_AS_HOLDER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_UPLINK  = 1'b1;

  // item function codes
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_TOKEN   = 1'b1;

  typedef enum logic [2:0] {
    M_HOLDER    = 3'd0,
    M_REQUESTED = 3'd1,
    M_WAITING   = 3'd2,
    M_READY     = 3'd3,
    M_UNSTARTED = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_REQ    = 2'd1,
    K_TOKEN  = 2'd2,
    K_TOKREQ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_BAD_TOKEN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic apply;    // queue update, mode step, entry fetch
    logic emit;     // settle the served entry and register the result
  } ttmn_cmd_t;

endpackage

// File: rtl/tree_token_mutex_node.sv
// ----------------------------------------------------------------------------
// tree_token_mutex_node
// One node of a tree token mutex: queues site requests, forwards requests
// toward the token, and hands the token to waiting sites oldest first.
// ----------------------------------------------------------------------------
// Raise start while busy is low to hand in an item (a request from a site, or
// the arrival of the token). Every item gives exactly one result. done rises
// from a register set in the emit step and holds for a single
// cycle. The receiver cannot stall the result, so sample it on that cycle.
// Each item has three steps (capture, queue update with entry fetch, emit).
// The next item may be accepted on the cycle done is high. The steps follow
// from the input capture register and from the registered read of the head
// entry, which the token send can only use in the cycle after the queue update.
// Write configuration only while the node is idle; it is taken up by the
// first item after reset.
// ----------------------------------------------------------------------------
module tree_token_mutex_node import ttmn_pkg::*; #(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int SITE_ID_BITS = DEF_SITE_ID_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // item channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    func,
  input  logic [SITE_ID_BITS-1:0] site_id,
  input  logic                    site_is_local,
  // result channel
  output logic                    done,
  output logic [1:0]              msg_kind,
  output logic [SITE_ID_BITS-1:0] dest_id,
  output logic                    dest_is_local,
  output logic [1:0]              node_mode,
  output logic [1:0]              status,
  // configuration
  input  logic                    wr_en,
  input  logic [CFG_INDEX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0]   wr_data
);

  ttmn_cmd_t cmd;

  // sequence each item through its steps
  ttmn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // hold the mode, the queues and the result registers
  ttmn_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .SITE_ID_BITS (SITE_ID_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .func          (func),
    .site_id       (site_id),
    .site_is_local (site_is_local),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .msg_kind      (msg_kind),
    .dest_id       (dest_id),
    .dest_is_local (dest_is_local),
    .node_mode     (node_mode),
    .status        (status)
  );

endmodule

// File: rtl/ttmn_ctrl.sv
// ----------------------------------------------------------------------------
// ttmn_ctrl
// Sequencer for one item: capture, apply, emit, then back to idle.
// ----------------------------------------------------------------------------
module ttmn_ctrl import ttmn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ttmn_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EMIT);
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    cmd.emit    = 1'b0;
    busy        = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ttmn_dpath.sv
// ----------------------------------------------------------------------------
// ttmn_dpath
// Mode and uplink registers, configuration registers, and a ring memory that
// holds the in-service batch followed by the waiting requests.
// ----------------------------------------------------------------------------
module ttmn_dpath import ttmn_pkg::*; #(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int SITE_ID_BITS = DEF_SITE_ID_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ttmn_cmd_t               cmd,
  input  logic                    func,
  input  logic [SITE_ID_BITS-1:0] site_id,
  input  logic                    site_is_local,
  input  logic                    wr_en,
  input  logic [CFG_INDEX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0]   wr_data,
  output logic [1:0]              msg_kind,
  output logic [SITE_ID_BITS-1:0] dest_id,
  output logic                    dest_is_local,
  output logic [1:0]              node_mode,
  output logic [1:0]              status
);

  // batch (oldest first, from head) then waiting entries; both can be near full
  localparam int RING = 2 * QUEUE_DEPTH;
  localparam int AW   = $clog2(RING);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = AW + 2;
  localparam int EW   = SITE_ID_BITS + 1;

  logic [EW-1:0] mem [RING];

  logic                    start_as_holder;
  logic [UPLINK_CFG_W-1:0] initial_uplink;

  mode_t                   mode;
  logic [SITE_ID_BITS-1:0] uplink;
  logic [AW-1:0]           head;
  logic [CW-1:0]           wait_count;
  logic [CW-1:0]           batch_count;

  logic                    func_q;
  logic [SITE_ID_BITS-1:0] sid_q;
  logic                    sloc_q;

  logic                    serve_q;
  kind_t                   kind_q;
  logic [SITE_ID_BITS-1:0] dest_q;
  status_t                 status_q;
  logic [EW-1:0]           rd_entry;

  // apply-step results
  mode_t                   mode_eff;
  logic [SITE_ID_BITS-1:0] uplink_eff;
  mode_t                   mode_a;
  kind_t                   kind_a;
  logic [SITE_ID_BITS-1:0] dest_a;
  status_t                 st_a;
  logic                    push_a;
  logic                    hold_a;
  logic                    serve_a;
  logic [CW-1:0]           wc_a;
  logic [CW-1:0]           bc_a;
  logic [SW-1:0]           tail_sum;
  logic [AW-1:0]           tail;
  logic [AW-1:0]           head_inc;

  // emit-step results
  mode_t                   mode_e;
  kind_t                   kind_e;
  logic [SITE_ID_BITS-1:0] dest_e;
  logic                    dloc_e;
  logic [SITE_ID_BITS-1:0] rd_id;
  logic                    rd_loc;

  assign rd_id  = rd_entry[EW-1:1];
  assign rd_loc = rd_entry[0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_as_holder <= 1'b1;
      initial_uplink  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_AS_HOLDER: start_as_holder <= wr_data[0];
        REG_INITIAL_UPLINK:  initial_uplink  <= wr_data[UPLINK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ring addressing
  always_comb begin
    tail_sum = SW'(head) + SW'(batch_count) + SW'(wait_count);
    if (tail_sum >= SW'(RING)) begin
      tail_sum = tail_sum - SW'(RING);
    end
    tail     = tail_sum[AW-1:0];
    head_inc = (head == AW'(RING - 1)) ? '0 : head + AW'(1);
  end

  // apply step: queue the request, step the mode, decide whether to serve
  always_comb begin
    mode_eff   = mode;
    uplink_eff = uplink;
    if (mode == M_UNSTARTED) begin
      mode_eff   = start_as_holder ? M_HOLDER : M_READY;
      uplink_eff = SITE_ID_BITS'(initial_uplink);
    end
    mode_a  = mode_eff;
    kind_a  = K_NONE;
    dest_a  = '0;
    st_a    = ST_OK;
    push_a  = 1'b0;
    hold_a  = 1'b0;
    serve_a = 1'b0;
    wc_a    = wait_count;
    bc_a    = batch_count;
    if (func_q == FUNC_REQUEST) begin
      if (wait_count < CW'(QUEUE_DEPTH)) begin
        push_a = 1'b1;
        wc_a   = wait_count + CW'(1);
      end else begin
        st_a = ST_DROPPED;
      end
      if (mode_eff == M_READY) begin
        mode_a = M_REQUESTED;
        kind_a = K_REQ;
        dest_a = uplink_eff;
      end else if (mode_eff == M_HOLDER) begin
        hold_a = 1'b1;
      end
    end else begin
      priority if (mode_eff == M_REQUESTED || mode_eff == M_READY) begin
        hold_a = 1'b1;
      end else if (mode_eff == M_WAITING) begin
        if (batch_count != '0) begin
          serve_a = 1'b1;
        end else begin
          hold_a = 1'b1;
        end
      end else begin
        st_a = ST_BAD_TOKEN;
      end
    end
    // holder: the whole waiting queue becomes the batch
    if (hold_a) begin
      mode_a = M_HOLDER;
      if (wc_a != '0) begin
        bc_a    = wc_a;
        wc_a    = '0;
        serve_a = 1'b1;
      end
    end
    if (serve_a) begin
      bc_a = bc_a - CW'(1);
    end
  end

  // emit step: when serving, hand the token to the oldest batch entry
  always_comb begin
    mode_e = mode;
    kind_e = kind_q;
    dest_e = dest_q;
    dloc_e = 1'b0;
    if (serve_q) begin
      dest_e = rd_id;
      dloc_e = rd_loc;
      kind_e = K_TOKREQ;
      priority if (batch_count != '0) begin
        mode_e = M_WAITING;
      end else if (wait_count != '0 || rd_loc) begin
        mode_e = M_REQUESTED;
      end else begin
        mode_e = M_READY;
        kind_e = K_TOKEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_UNSTARTED;
      uplink      <= '0;
      head        <= '0;
      wait_count  <= '0;
      batch_count <= '0;
      serve_q     <= 1'b0;
    end else if (cmd.apply) begin
      mode        <= mode_a;
      uplink      <= uplink_eff;
      wait_count  <= wc_a;
      batch_count <= bc_a;
      serve_q     <= serve_a;
      if (serve_a) begin
        head <= head_inc;
      end
    end else if (cmd.emit) begin
      mode <= mode_e;
      if (serve_q && mode_e == M_READY) begin
        uplink <= rd_id;
      end
    end
  end

  // item capture and per-step payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      sid_q  <= site_id;
      sloc_q <= site_is_local;
    end
    if (cmd.apply) begin
      kind_q   <= kind_a;
      dest_q   <= dest_a;
      status_q <= st_a;
    end
    if (cmd.emit) begin
      msg_kind      <= kind_e;
      dest_id       <= dest_e;
      dest_is_local <= dloc_e;
      node_mode     <= mode_e[1:0];
      status        <= status_q;
    end
  end

  // ring memory; forward the entry written this cycle when it is also the head
  always_ff @(posedge clk) begin
    if (cmd.apply && push_a) begin
      mem[tail] <= {sid_q, sloc_q};
    end
    if (cmd.apply) begin
      if (push_a && tail == head) begin
        rd_entry <= {sid_q, sloc_q};
      end else begin
        rd_entry <= mem[head];
      end
    end
  end

endmodule
